// File: sv/s5scan_pkg.sv
// ----------------------------------------------------------------------------
// s5scan_pkg: shared types and constants of the _S5_ sleep-type scanner
// AML opcodes, the name pattern, item and result types and the integer
// object decode helpers.
// ----------------------------------------------------------------------------
package s5scan_pkg;

  // AML opcodes and prefixes
  localparam logic [7:0] NAME_OP      = 8'h08;
  localparam logic [7:0] ROOT_PREFIX  = 8'h5C;
  localparam logic [7:0] PACKAGE_OP   = 8'h12;
  localparam logic [7:0] ONE_OP       = 8'h01;
  localparam logic [7:0] ONES_OP      = 8'hFF;
  localparam logic [7:0] BYTE_PREFIX  = 8'h0A;
  localparam logic [7:0] WORD_PREFIX  = 8'h0B;
  localparam logic [7:0] DWORD_PREFIX = 8'h0C;

  // "_S5_" as it appears in the byte stream, first byte highest
  localparam logic [31:0] S5_NAME = 32'h5F53_355F;

  localparam int unsigned WinBytes = 6;
  localparam int unsigned WinBits  = 8 * WinBytes;

  // window contents that precede the package opcode, newest byte lowest
  localparam logic [39:0]      NAME_SEQ      = {NAME_OP, S5_NAME};
  localparam logic [WinBits-1:0] ROOT_NAME_SEQ = {NAME_OP, ROOT_PREFIX, S5_NAME};

  typedef struct packed {
    logic [7:0] table_byte;
    logic       last_byte;
  } s5scan_item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] sleep_type_a;
    logic [2:0] sleep_type_b;
  } s5scan_res_t;

  // decode of an integer object opcode
  typedef struct packed {
    logic       has_data;  // data bytes follow the opcode
    logic [1:0] skip;      // data bytes after the first one
    logic [2:0] value;     // value of a constant opcode
  } s5scan_int_t;

  function automatic s5scan_int_t s5scan_int_decode(logic [7:0] op);
    s5scan_int_t info;
    info = '{has_data: 1'b0, skip: 2'd0, value: 3'd0};
    unique case (op)
      ONE_OP:       info.value = 3'd1;
      ONES_OP:      info.value = 3'd7;
      BYTE_PREFIX:  info.has_data = 1'b1;
      WORD_PREFIX:  begin
        info.has_data = 1'b1;
        info.skip     = 2'd1;
      end
      DWORD_PREFIX: begin
        info.has_data = 1'b1;
        info.skip     = 2'd3;
      end
      default:      info.value = 3'd0;
    endcase
    return info;
  endfunction

endpackage

// File: sv/s5scan_if.sv
// ----------------------------------------------------------------------------
// s5scan_if: valid/ready channels of the _S5_ sleep-type scanner
// Byte input channel and result output channel.
// ----------------------------------------------------------------------------
interface s5scan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       last_byte;

  modport source (output valid, output table_byte, output last_byte, input ready);
  modport sink   (input valid, input table_byte, input last_byte, output ready);
endinterface

interface s5scan_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [2:0] sleep_type_a;
  logic [2:0] sleep_type_b;

  modport source (output valid, output found, output sleep_type_a,
                  output sleep_type_b, input ready);
  modport sink   (input valid, input found, input sleep_type_a,
                  input sleep_type_b, output ready);
endinterface

// File: sv/aml_s5_sleep_type_scanner.sv
// ----------------------------------------------------------------------------
// aml_s5_sleep_type_scanner: _S5_ sleep-type scanner for AML table bodies
// Finds the _S5_ package in a stream of AML bytes and reports its sleep types.
// ----------------------------------------------------------------------------
// Usage
//   item_i carries one AML body byte per transfer, in table order, with
//   last_byte set on the final byte of each table. result_o carries at most
//   one transfer per input byte: found with both sleep types when the _S5_
//   package has been decoded, or a not-found transfer (types zero) when a
//   table ends without it.
//   An accepted byte is held in the input register, and its result is
//   registered in the output register.
//   Throughput: one byte per cycle while result_o is not stalled; the parser
//   state is a single register set updated by one level of logic per byte.
//   Reset clears the name window and the parse phase; the block starts in
//   search. After a successful decode the block stays resolved until reset
//   and swallows every later byte without a result.
//   When the receiver stalls, the result waits in the output register and
//   one further byte is held in the input register; item_i.ready then drops
//   until the output drains.
// ----------------------------------------------------------------------------
module aml_s5_sleep_type_scanner (
  input  logic         clk_i,
  input  logic         rst_ni,
  s5scan_in_if.sink    item_i,
  s5scan_out_if.source result_o
);
  import s5scan_pkg::*;

  // input register
  logic         in_vld_q, in_vld_d;
  s5scan_item_t in_item_q;

  // output register
  logic         out_vld_q, out_vld_d;
  s5scan_res_t  out_res_q;

  logic         out_free;     // output register can take a new result
  logic         in_fire;      // byte transfer on item_i
  logic         step;         // parser consumes the held byte
  logic         res_valid;
  s5scan_res_t  res;
  logic         resolved;

  assign out_free     = !out_vld_q || result_o.ready;
  assign step         = in_vld_q && out_free;
  assign item_i.ready = !in_vld_q || out_free;
  assign in_fire      = item_i.valid && item_i.ready;

  s5scan_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .step_item_i (in_item_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .resolved_o  (resolved)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = step && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= '{table_byte: item_i.table_byte, last_byte: item_i.last_byte};
    end
    if (step && res_valid) begin
      out_res_q <= res;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.found        = out_res_q.found;
  assign result_o.sleep_type_a = out_res_q.sleep_type_a;
  assign result_o.sleep_type_b = out_res_q.sleep_type_b;

  // a found result only exists once the parser has resolved
  a_found_resolved : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_res_q.found |-> resolved)
    else $error("found result without resolved parser");

  // resolved is sticky until reset
  a_resolved_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    resolved |=> resolved)
    else $error("parser left resolved state");

  // a not-found result carries zero sleep types
  a_not_found_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_res_q.found |->
      out_res_q.sleep_type_a == 3'd0 && out_res_q.sleep_type_b == 3'd0)
    else $error("not-found result with nonzero sleep type");

  // a held byte is not dropped while the output is blocked
  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_free |=> in_vld_q)
    else $error("held byte lost during output stall");

endmodule

// File: sv/s5scan_parser.sv
// ----------------------------------------------------------------------------
// s5scan_parser: AML byte parser for the _S5_ package
// Name window, package walk and integer decode; one byte per step.
// ----------------------------------------------------------------------------
module s5scan_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  s5scan_pkg::s5scan_item_t step_item_i,
  output logic                     res_valid_o,
  output s5scan_pkg::s5scan_res_t  res_o,
  output logic                     resolved_o
);
  import s5scan_pkg::*;

  typedef enum logic [3:0] {
    PH_SEARCH,
    PH_PKGLEN,
    PH_PKGSKIP,
    PH_COUNT,
    PH_OPA,
    PH_A_LOW,
    PH_A_REST,
    PH_OPB,
    PH_B_LOW,
    PH_B_REST,
    PH_RESOLVED
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [WinBits-1:0] win_q, win_d;
  logic [1:0]         skip_q, skip_d;
  logic               many_q, many_d;    // element count above one
  logic [2:0]         first_q, first_d;
  logic [2:0]         low_q, low_d;

  logic        active;
  logic        done_a, done_b, emit, not_found;
  logic [2:0]  val, res_a, res_b;
  logic [7:0]  tb;
  s5scan_int_t op_info;

  assign tb     = step_item_i.table_byte;
  assign active = step_i && (phase_q != PH_RESOLVED);

  always_comb begin
    phase_d   = phase_q;
    win_d     = win_q;
    skip_d    = skip_q;
    many_d    = many_q;
    first_d   = first_q;
    low_d     = low_q;
    done_a    = 1'b0;
    done_b    = 1'b0;
    emit      = 1'b0;
    not_found = 1'b0;
    val       = 3'd0;
    res_a     = 3'd0;
    res_b     = 3'd0;
    op_info   = s5scan_int_decode(tb);

    if (active) begin
      unique case (phase_q)
        PH_SEARCH: begin
          if (tb == PACKAGE_OP &&
              (win_q[39:0] == NAME_SEQ || win_q == ROOT_NAME_SEQ)) begin
            phase_d = PH_PKGLEN;
            win_d   = '0;
          end else begin
            win_d = {win_q[WinBits-9:0], tb};
          end
        end
        PH_PKGLEN: begin
          skip_d  = tb[7:6];
          phase_d = (tb[7:6] != 2'd0) ? PH_PKGSKIP : PH_COUNT;
        end
        PH_PKGSKIP: begin
          skip_d = skip_q - 2'd1;
          if (skip_q == 2'd1) phase_d = PH_COUNT;
        end
        PH_COUNT: begin
          many_d  = (tb > 8'd1);
          phase_d = PH_OPA;
        end
        PH_OPA, PH_OPB: begin
          if (op_info.has_data) begin
            skip_d  = op_info.skip;
            low_d   = 3'd0;
            phase_d = (phase_q == PH_OPA) ? PH_A_LOW : PH_B_LOW;
          end else begin
            low_d  = op_info.value;
            val    = op_info.value;
            done_a = (phase_q == PH_OPA);
            done_b = (phase_q == PH_OPB);
          end
        end
        PH_A_LOW, PH_B_LOW: begin
          low_d = tb[2:0];
          val   = tb[2:0];
          if (skip_q == 2'd0) begin
            done_a = (phase_q == PH_A_LOW);
            done_b = (phase_q == PH_B_LOW);
          end else begin
            phase_d = (phase_q == PH_A_LOW) ? PH_A_REST : PH_B_REST;
          end
        end
        PH_A_REST, PH_B_REST: begin
          skip_d = skip_q - 2'd1;
          val    = low_q;
          if (skip_q == 2'd1) begin
            done_a = (phase_q == PH_A_REST);
            done_b = (phase_q == PH_B_REST);
          end
        end
        default: phase_d = PH_SEARCH;
      endcase

      // integer A done: second integer or answer with B equal to A
      if (done_a) begin
        first_d = val;
        if (many_q) begin
          phase_d = PH_OPB;
        end else begin
          emit  = 1'b1;
          res_a = val;
          res_b = val;
        end
      end
      if (done_b) begin
        emit  = 1'b1;
        res_a = first_q;
        res_b = val;
      end
      if (emit) phase_d = PH_RESOLVED;

      // table end without an answer drops any partial package
      if (step_item_i.last_byte && !emit) begin
        not_found = 1'b1;
        phase_d   = PH_SEARCH;
        win_d     = '0;
        skip_d    = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      win_q   <= '0;
      skip_q  <= 2'd0;
      many_q  <= 1'b0;
      first_q <= 3'd0;
      low_q   <= 3'd0;
    end else begin
      phase_q <= phase_d;
      win_q   <= win_d;
      skip_q  <= skip_d;
      many_q  <= many_d;
      first_q <= first_d;
      low_q   <= low_d;
    end
  end

  assign res_valid_o = emit || not_found;
  assign res_o       = '{found: emit, sleep_type_a: res_a, sleep_type_b: res_b};
  assign resolved_o  = (phase_q == PH_RESOLVED);

endmodule
